// ===== hdl/bfop_pkg.sv =====
package bfop_pkg;

   // Fixed field widths
   localparam int MAX_LENGTH_WIDTH = 9;
   localparam int POLICY_WIDTH     = 2;
   localparam int VALUE_WIDTH      = 32;
   localparam int STATUS_WIDTH     = 2;
   localparam int LENGTH_WIDTH     = 9;
   localparam int CSR_INDEX_WIDTH  = 1;
   localparam int CSR_DATA_WIDTH   = 9;

   // Default sizing
   localparam int DEFAULT_DEPTH      = 256;
   localparam int DEFAULT_DATA_WIDTH = 32;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_LENGTH      = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OVERFLOW_POLICY = 1'd1;

   // Operation codes
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   // Overflow policies
   localparam logic [POLICY_WIDTH-1:0] POLICY_REJECT      = 2'd0;
   localparam logic [POLICY_WIDTH-1:0] POLICY_DROP_OLDEST = 2'd1;
   localparam logic [POLICY_WIDTH-1:0] POLICY_DROP_NEWEST = 2'd2;

   // Result status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_REJECT = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic latch_item;
      logic execute;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } stat_type;

endpackage

// ===== hdl/bounded_fifo_overflow_policy_unit.sv =====
// Bounded FIFO of data words with a length limit and an overflow policy.
// Request channel (req_): one beat carries a push (req_func 0, word in
// req_push_value) or a pop (req_func 1). Response channel (rsp_): one beat
// per request with rsp_status (ok, push rejected, pop on empty queue),
// rsp_pop_value (head word on a good pop, zero otherwise) and
// rsp_queue_length, the number of words held after the operation.
// Configuration (csr_): write max_length (index 0, 0 means store depth
// only) and overflow_policy (index 1: reject, drop oldest, drop newest)
// while no request is outstanding.
// Timing: a request is taken in the idle state, executed in the next cycle
// (store write, or registered store read of the head word) and then loaded
// into the response register in the load state, once no stalled response waits.
// No new request is taken until the last one has been loaded; the
// controller's three-state sequence around the single store port sets this.
// A waiting response does not block acceptance or execution of the next
// request; that request holds in its load step until the response is taken.
// Reset (synchronous) empties the queue and clears both registers; the
// store contents are left as they are and are never read before written.
module bounded_fifo_overflow_policy_unit #(
   parameter int DEPTH      = bfop_pkg::DEFAULT_DEPTH,
   parameter int DATA_WIDTH = bfop_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_func,
   input  logic [bfop_pkg::VALUE_WIDTH-1:0]     req_push_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bfop_pkg::STATUS_WIDTH-1:0]    rsp_status,
   output logic [bfop_pkg::VALUE_WIDTH-1:0]     rsp_pop_value,
   output logic [bfop_pkg::LENGTH_WIDTH-1:0]    rsp_queue_length,
   input  logic                                 csr_we,
   input  logic [bfop_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bfop_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   bfop_pkg::cmd_type  cmd;
   bfop_pkg::stat_type stat;

   // Sequence each request: accept, execute, load the response
   bfop_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // Queue pointers, store, configuration and response register
   bfop_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_func),
      .req_push_value   (req_push_value),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_pop_value    (rsp_pop_value),
      .rsp_queue_length (rsp_queue_length)
   );

   // One request in flight: an accepted beat blocks the next cycle
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in flight");

   // A loaded response is presented in the following cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |=> rsp_valid)
      else $error("loaded response not presented");

   // Pop on empty queue reports an empty queue and no word
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bfop_pkg::STATUS_EMPTY)
         |-> (rsp_queue_length == '0 && rsp_pop_value == '0))
      else $error("empty pop response carries data or length");

   // A rejected push returns no word
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bfop_pkg::STATUS_REJECT) |-> (rsp_pop_value == '0))
      else $error("rejected push carries a word");

endmodule

// ===== hdl/bfop_ctrl.sv =====
module bfop_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  bfop_pkg::stat_type stat,
   output logic              req_stall,
   output bfop_pkg::cmd_type  cmd
);

   bfop_pkg::state_type state_ff;
   bfop_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfop_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfop_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = bfop_pkg::ST_EXEC;
            end
         end
         bfop_pkg::ST_EXEC: begin
            state_in = bfop_pkg::ST_LOAD;
         end
         bfop_pkg::ST_LOAD: begin
            if (!stat.out_busy) begin
               state_in = bfop_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfop_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall       = 1'b1;
      cmd.latch_item  = 1'b0;
      cmd.execute     = 1'b0;
      cmd.load_result = 1'b0;
      case (state_ff)
         bfop_pkg::ST_IDLE: begin
            req_stall      = 1'b0;
            cmd.latch_item = req_valid;
         end
         bfop_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         bfop_pkg::ST_LOAD: begin
            cmd.load_result = !stat.out_busy;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== hdl/bfop_datapath.sv =====
module bfop_datapath #(
   parameter int DEPTH      = bfop_pkg::DEFAULT_DEPTH,
   parameter int DATA_WIDTH = bfop_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bfop_pkg::cmd_type                       cmd,
   output bfop_pkg::stat_type                      stat,
   input  logic                                   req_func,
   input  logic [bfop_pkg::VALUE_WIDTH-1:0]       req_push_value,
   input  logic                                   csr_we,
   input  logic [bfop_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [bfop_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [bfop_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic [bfop_pkg::VALUE_WIDTH-1:0]       rsp_pop_value,
   output logic [bfop_pkg::LENGTH_WIDTH-1:0]      rsp_queue_length
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = $clog2(2 * DEPTH);
   localparam int XW = (SW > bfop_pkg::MAX_LENGTH_WIDTH + 1) ? SW
                                                              : bfop_pkg::MAX_LENGTH_WIDTH + 1;
   localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

   // Configuration
   logic [bfop_pkg::MAX_LENGTH_WIDTH-1:0] max_length_ff;
   logic [bfop_pkg::POLICY_WIDTH-1:0]     policy_ff;

   // Queue state
   logic [AW-1:0]         head_ff;
   logic [AW-1:0]         head_in;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic [DATA_WIDTH-1:0] entry_store_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Latched item and pending result
   logic                                 item_func_ff;
   logic [bfop_pkg::VALUE_WIDTH-1:0]     item_value_ff;
   logic [bfop_pkg::STATUS_WIDTH-1:0]    res_status_ff;
   logic [bfop_pkg::STATUS_WIDTH-1:0]    res_status_in;
   logic                                 res_pop_ok_ff;

   // Output register
   logic                                 rsp_valid_ff;
   logic [bfop_pkg::STATUS_WIDTH-1:0]    rsp_status_ff;
   logic [bfop_pkg::VALUE_WIDTH-1:0]     rsp_pop_value_ff;
   logic [bfop_pkg::LENGTH_WIDTH-1:0]    rsp_queue_length_ff;

   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic            rd_en;
   logic [XW-1:0]   cnt_x;
   logic [XW-1:0]   max_x;
   logic [XW-1:0]   keep_x;
   logic [XW-1:0]   head_x;
   logic            limited;
   logic            at_limit;
   logic [63:0]     rd_wide;

   function automatic logic [AW-1:0] wrap_idx(input logic [XW-1:0] s);
      logic [XW-1:0] r;
      r = (s >= DEPTH_X) ? (s - DEPTH_X) : s;
      return AW'(r);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= '0;
         policy_ff     <= bfop_pkg::POLICY_REJECT;
      end else if (csr_we) begin
         case (csr_index)
            bfop_pkg::CSR_MAX_LENGTH: begin
               max_length_ff <= csr_wdata;
            end
            bfop_pkg::CSR_OVERFLOW_POLICY: begin
               policy_ff <= csr_wdata[bfop_pkg::POLICY_WIDTH-1:0];
            end
            default: begin
               max_length_ff <= max_length_ff;
            end
         endcase
      end
   end

   always_comb begin
      cnt_x    = XW'(count_ff);
      max_x    = XW'(max_length_ff);
      keep_x   = max_x - XW'(1);
      head_x   = XW'(head_ff);
      limited  = (max_x != '0) && (max_x <= DEPTH_X);
      at_limit = limited && (cnt_x >= max_x);

      head_in       = head_ff;
      count_in      = count_ff;
      res_status_in = bfop_pkg::STATUS_OK;
      wr_en         = 1'b0;
      wr_addr       = wrap_idx(head_x + cnt_x);
      rd_en         = 1'b0;

      if (item_func_ff == bfop_pkg::FUNC_POP) begin
         if (count_ff == '0) begin
            res_status_in = bfop_pkg::STATUS_EMPTY;
         end else begin
            rd_en    = 1'b1;
            head_in  = wrap_idx(head_x + XW'(1));
            count_in = count_ff - CW'(1);
         end
      end else if (at_limit) begin
         case (policy_ff)
            bfop_pkg::POLICY_DROP_OLDEST: begin
               // the tail slot is unchanged; the head moves past the dropped words
               wr_en    = 1'b1;
               head_in  = wrap_idx(head_x + (cnt_x - keep_x));
               count_in = CW'(max_x);
            end
            bfop_pkg::POLICY_DROP_NEWEST: begin
               wr_en    = 1'b1;
               wr_addr  = wrap_idx(head_x + keep_x);
               count_in = CW'(max_x);
            end
            default: begin
               res_status_in = bfop_pkg::STATUS_REJECT;
            end
         endcase
      end else if (cnt_x >= DEPTH_X) begin
         res_status_in = bfop_pkg::STATUS_REJECT;
      end else begin
         wr_en    = 1'b1;
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.execute) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && wr_en) begin
         entry_store_ff[wr_addr] <= DATA_WIDTH'(item_value_ff);
      end
      if (cmd.execute && rd_en) begin
         rd_data_ff <= entry_store_ff[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         item_func_ff  <= req_func;
         item_value_ff <= req_push_value;
      end
      if (cmd.execute) begin
         res_status_ff <= res_status_in;
         res_pop_ok_ff <= rd_en;
      end
   end

   assign rd_wide = 64'(rd_data_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_status_ff       <= res_status_ff;
         rsp_pop_value_ff    <= res_pop_ok_ff ? rd_wide[bfop_pkg::VALUE_WIDTH-1:0] : '0;
         rsp_queue_length_ff <= bfop_pkg::LENGTH_WIDTH'(count_ff);
      end
   end

   assign stat.out_busy    = rsp_valid_ff && rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_pop_value    = rsp_pop_value_ff;
   assign rsp_queue_length = rsp_queue_length_ff;

endmodule

// ===== test/fifo_result_checker.sv =====
`timescale 1ns / 100ps

module fifo_result_checker #(
   parameter int DEPTH = bfop_pkg::DEFAULT_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic                                 req_func,
   input  logic [bfop_pkg::VALUE_WIDTH-1:0]     req_push_value,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [bfop_pkg::STATUS_WIDTH-1:0]    rsp_status,
   input  logic [bfop_pkg::VALUE_WIDTH-1:0]     rsp_pop_value,
   input  logic [bfop_pkg::LENGTH_WIDTH-1:0]    rsp_queue_length,
   input  logic                                 csr_we,
   input  logic [bfop_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bfop_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                   mismatches,
   output int                                   outstanding
);

   typedef struct packed {
      logic [bfop_pkg::STATUS_WIDTH-1:0] status;
      logic [bfop_pkg::VALUE_WIDTH-1:0]  pop_value;
      logic [bfop_pkg::LENGTH_WIDTH-1:0] queue_length;
   } fifo_result_type;

   logic [bfop_pkg::VALUE_WIDTH-1:0]      held_words[$];
   fifo_result_type                       due_results[$];
   logic [bfop_pkg::MAX_LENGTH_WIDTH-1:0] length_limit;
   logic [bfop_pkg::POLICY_WIDTH-1:0]     drop_policy;
   int                                    fail_tally;

   // Apply one push or pop to the mirrored queue and return its response.
   function automatic fifo_result_type apply_fifo_op(logic func,
                                                     logic [bfop_pkg::VALUE_WIDTH-1:0] word);
      fifo_result_type r;
      int              keep;
      bit              bounded;
      r.status    = bfop_pkg::STATUS_OK;
      r.pop_value = '0;
      bounded     = (length_limit != 0) && (int'(length_limit) <= DEPTH);
      keep        = int'(length_limit) - 1;
      if (func == bfop_pkg::FUNC_PUSH) begin
         if (bounded && held_words.size() >= int'(length_limit)) begin
            if (drop_policy == bfop_pkg::POLICY_DROP_OLDEST) begin
               while (held_words.size() > keep) void'(held_words.pop_front());
               held_words.push_back(word);
            end else if (drop_policy == bfop_pkg::POLICY_DROP_NEWEST) begin
               while (held_words.size() > keep) void'(held_words.pop_back());
               held_words.push_back(word);
            end else begin
               r.status = bfop_pkg::STATUS_REJECT;
            end
         end else if (held_words.size() >= DEPTH) begin
            r.status = bfop_pkg::STATUS_REJECT;
         end else begin
            held_words.push_back(word);
         end
      end else if (held_words.size() == 0) begin
         r.status = bfop_pkg::STATUS_EMPTY;
      end else begin
         r.pop_value = held_words.pop_front();
      end
      r.queue_length = bfop_pkg::LENGTH_WIDTH'(held_words.size());
      return r;
   endfunction

   always @(posedge clock) begin : watch
      fifo_result_type want;
      fifo_result_type got;
      if (reset) begin
         held_words.delete();
         due_results.delete();
         length_limit = '0;
         drop_policy  = bfop_pkg::POLICY_REJECT;
      end else begin
         // Compare a response beat with the oldest expectation.
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_pop_value, rsp_queue_length};
            if (due_results.size() == 0) begin
               fail_tally++;
               if (fail_tally <= 10)
                  $display("unexpected response at %0t: status %0d value %h length %0d",
                           $time, got.status, got.pop_value, got.queue_length);
            end else begin
               want = due_results.pop_front();
               if (got !== want) begin
                  fail_tally++;
                  if (fail_tally <= 10) begin
                     $display("mismatch at %0t: expected status %0d value %h length %0d,",
                              $time, want.status, want.pop_value, want.queue_length);
                     $display("   got status %0d value %h length %0d",
                              got.status, got.pop_value, got.queue_length);
                  end
               end
            end
         end
         if (req_valid && !req_stall)
            due_results.push_back(apply_fifo_op(req_func, req_push_value));
         if (csr_we) begin
            if (csr_index == bfop_pkg::CSR_MAX_LENGTH)
               length_limit = csr_wdata[bfop_pkg::MAX_LENGTH_WIDTH-1:0];
            else if (csr_index == bfop_pkg::CSR_OVERFLOW_POLICY)
               drop_policy = csr_wdata[bfop_pkg::POLICY_WIDTH-1:0];
         end
      end
      mismatches  <= fail_tally;
      outstanding <= due_results.size();
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   logic                                 clock            = 1'b0;
   logic                                 reset            = 1'b1;
   logic                                 req_valid        = 1'b0;
   logic                                 req_stall;
   logic                                 req_func         = bfop_pkg::FUNC_PUSH;
   logic [bfop_pkg::VALUE_WIDTH-1:0]     req_push_value   = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall        = 1'b0;
   logic [bfop_pkg::STATUS_WIDTH-1:0]    rsp_status;
   logic [bfop_pkg::VALUE_WIDTH-1:0]     rsp_pop_value;
   logic [bfop_pkg::LENGTH_WIDTH-1:0]    rsp_queue_length;
   logic                                 csr_we           = 1'b0;
   logic [bfop_pkg::CSR_INDEX_WIDTH-1:0] csr_index        = bfop_pkg::CSR_MAX_LENGTH;
   logic [bfop_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata        = '0;

   int mismatches;
   int outstanding;
   int beat_total;
   int setting_total;
   bit idle_on;

   // 12 ns clock: 6 ns high, 6 ns low.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   bounded_fifo_overflow_policy_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_pop_value    (rsp_pop_value),
      .rsp_queue_length (rsp_queue_length),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   fifo_result_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_pop_value    (rsp_pop_value),
      .rsp_queue_length (rsp_queue_length),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   // Response-side back-pressure: runs of stall or no stall, mostly short,
   // now and then long. Hold stall low whenever idling is switched off.
   always @(posedge clock) begin : rsp_idler
      int run_left;
      int pick;
      if (reset || !idle_on) begin
         rsp_stall <= 1'b0;
         run_left  = 0;
      end else if (run_left > 0) begin
         run_left--;
      end else begin
         pick      = $urandom_range(99);
         rsp_stall <= (pick < 30);
         run_left  = ($urandom_range(99) < 90) ? $urandom_range(0, 3) : $urandom_range(15, 40);
      end
   end

   // Sender gap length: mostly back to back, some short, a few long.
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Present one request beat and hold it until accepted. Valid stays high
   // into the next beat when there is no gap, so it is never dropped and
   // raised again within one step.
   task automatic send_beat(input logic func, input logic [bfop_pkg::VALUE_WIDTH-1:0] word);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_push_value <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beat_total++;
   endtask

   // Pause the sender until every expected response has been taken, then
   // allow the block to settle.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   // Write both registers on consecutive edges while the block is idle.
   // Spare upper bits of the policy write are randomised; only the low
   // two bits count.
   task automatic configure(input logic [bfop_pkg::MAX_LENGTH_WIDTH-1:0] limit,
                            input logic [bfop_pkg::POLICY_WIDTH-1:0] policy);
      drain();
      csr_we    <= 1'b1;
      csr_index <= bfop_pkg::CSR_MAX_LENGTH;
      csr_wdata <= limit;
      @(posedge clock);
      csr_index <= bfop_pkg::CSR_OVERFLOW_POLICY;
      csr_wdata <= {bfop_pkg::CSR_DATA_WIDTH'($urandom_range(0, 127))
                    << bfop_pkg::POLICY_WIDTH} | policy;
      @(posedge clock);
      csr_we    <= 1'b0;
      setting_total++;
   endtask

   task automatic random_beats(input int count, input int push_pct);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < push_pct)
            send_beat(bfop_pkg::FUNC_PUSH, $urandom());
         else
            send_beat(bfop_pkg::FUNC_POP, $urandom());
      end
   endtask

   initial begin : stimulus
      int                                    pick;
      logic [bfop_pkg::MAX_LENGTH_WIDTH-1:0] limit;
      beat_total    = 0;
      setting_total = 0;
      idle_on       = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: pop on empty, extreme words, then each policy at its limit.
      send_beat(bfop_pkg::FUNC_POP, '1);
      send_beat(bfop_pkg::FUNC_PUSH, '0);
      send_beat(bfop_pkg::FUNC_PUSH, '1);
      send_beat(bfop_pkg::FUNC_POP, '0);
      send_beat(bfop_pkg::FUNC_POP, '0);

      // Reject at limit: third push is refused, queue unchanged.
      configure(9'd2, bfop_pkg::POLICY_REJECT);
      send_beat(bfop_pkg::FUNC_PUSH, 32'hA5A5_A5A5);
      send_beat(bfop_pkg::FUNC_PUSH, 32'h5A5A_5A5A);
      send_beat(bfop_pkg::FUNC_PUSH, 32'hDEAD_BEEF);
      send_beat(bfop_pkg::FUNC_POP, '0);

      // Drop oldest: the head advances to make room.
      configure(9'd3, bfop_pkg::POLICY_DROP_OLDEST);
      send_beat(bfop_pkg::FUNC_PUSH, 32'h0000_0001);
      send_beat(bfop_pkg::FUNC_PUSH, 32'h8000_0000);
      send_beat(bfop_pkg::FUNC_PUSH, 32'h1234_5678);

      // Drop newest with the limit lowered below the current length.
      configure(9'd2, bfop_pkg::POLICY_DROP_NEWEST);
      send_beat(bfop_pkg::FUNC_PUSH, 32'hCAFE_F00D);
      send_beat(bfop_pkg::FUNC_PUSH, 32'h0F0F_0F0F);

      // Unused policy code acts as reject.
      configure(9'd1, 2'd3);
      send_beat(bfop_pkg::FUNC_PUSH, 32'hFFFF_0000);
      send_beat(bfop_pkg::FUNC_POP, '0);
      send_beat(bfop_pkg::FUNC_POP, '0);

      // Limit of one with drop oldest: a push onto the lone word replaces it.
      configure(9'd1, bfop_pkg::POLICY_DROP_OLDEST);
      send_beat(bfop_pkg::FUNC_PUSH, 32'h0000_FFFF);
      send_beat(bfop_pkg::FUNC_PUSH, 32'h7FFF_FFFF);

      // Limit beyond the store depth means no limit.
      configure(9'd300, bfop_pkg::POLICY_REJECT);
      send_beat(bfop_pkg::FUNC_PUSH, 32'h3C3C_3C3C);
      send_beat(bfop_pkg::FUNC_POP, '0);
      send_beat(bfop_pkg::FUNC_POP, '0);

      // Fill the store with no limit: pushes past the depth are refused.
      configure(9'd0, bfop_pkg::POLICY_REJECT);
      random_beats(280, 100);
      random_beats(20, 0);

      // Store full still refuses with a drop policy when the limit is out of range.
      configure(9'd511, bfop_pkg::POLICY_DROP_OLDEST);
      random_beats(30, 100);

      // Limit equal to the depth, then a deep eviction down to a short limit.
      configure(9'd256, bfop_pkg::POLICY_DROP_NEWEST);
      random_beats(5, 100);
      configure(9'd5, bfop_pkg::POLICY_DROP_OLDEST);
      random_beats(10, 70);

      // Random settings; every fourth phase runs with no idling at all.
      for (int p = 0; p < 12; p++) begin
         pick = $urandom_range(9);
         case (pick)
            0:       limit = 9'd0;
            1:       limit = 9'd256;
            2:       limit = bfop_pkg::MAX_LENGTH_WIDTH'($urandom_range(257, 511));
            3:       limit = bfop_pkg::MAX_LENGTH_WIDTH'($urandom_range(9, 255));
            default: limit = bfop_pkg::MAX_LENGTH_WIDTH'($urandom_range(1, 8));
         endcase
         configure(limit, bfop_pkg::POLICY_WIDTH'($urandom_range(0, 3)));
         idle_on = (p % 4 != 3);
         random_beats(60, $urandom_range(40, 75));
      end
      idle_on = 1'b1;

      // Let the last responses arrive, then give the verdict.
      drain();
      repeat (10) @(posedge clock);
      $display("Run covered %0d request beats over %0d register settings,",
               beat_total, setting_total);
      $display("including store-full refusals, all three policies and an unused policy code.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Give up well beyond the slowest correct run.
   initial begin : watchdog
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/bfop_pkg.sv
hdl/bfop_ctrl.sv
hdl/bfop_datapath.sv
hdl/bounded_fifo_overflow_policy_unit.sv
test/fifo_result_checker.sv
test/testbench.sv
